>>> hw/rtl/jsv_pkg.sv
`timescale 1ns / 1ps
package jsv_pkg;

   typedef enum logic [4:0] {
      P_TOP, P_AFTER_TOP, P_ARR_FIRST, P_ARR_VALUE, P_ARR_AFTER,
      P_OBJ_FIRST, P_OBJ_KEY, P_OBJ_COLON, P_OBJ_VALUE, P_OBJ_AFTER,
      P_STR, P_ESC, P_HEX, P_LIT, P_NUM_SIGN, P_NUM_ZERO, P_NUM_INT,
      P_NUM_FRAC0, P_NUM_FRAC, P_NUM_EXP0, P_NUM_EXPSIGN, P_NUM_EXP, P_FAILED
   } phase_type;

   localparam logic KIND_OBJ = 1'b0;
   localparam logic KIND_ARR = 1'b1;

   localparam logic [3:0] EV_NONE      = 4'd0;
   localparam logic [3:0] EV_OBJ_OPEN  = 4'd1;
   localparam logic [3:0] EV_OBJ_CLOSE = 4'd2;
   localparam logic [3:0] EV_ARR_OPEN  = 4'd3;
   localparam logic [3:0] EV_ARR_CLOSE = 4'd4;
   localparam logic [3:0] EV_KEY_DATA  = 4'd5;
   localparam logic [3:0] EV_KEY_END   = 4'd6;
   localparam logic [3:0] EV_STR_DATA  = 4'd7;
   localparam logic [3:0] EV_STR_END   = 4'd8;
   localparam logic [3:0] EV_NUM       = 4'd9;
   localparam logic [3:0] EV_TRUE      = 4'd10;
   localparam logic [3:0] EV_FALSE     = 4'd11;
   localparam logic [3:0] EV_NULL      = 4'd12;

   localparam logic [4:0] E_OK         = 5'd0;
   localparam logic [4:0] E_DEPTH      = 5'd1;
   localparam logic [4:0] E_END        = 5'd2;
   localparam logic [4:0] E_COLON      = 5'd3;
   localparam logic [4:0] E_OBJ_COMMA  = 5'd4;
   localparam logic [4:0] E_OBJ_UNTERM = 5'd5;
   localparam logic [4:0] E_ARR_COMMA  = 5'd6;
   localparam logic [4:0] E_ARR_UNTERM = 5'd7;
   localparam logic [4:0] E_EXP_STR    = 5'd8;
   localparam logic [4:0] E_CTRL       = 5'd9;
   localparam logic [4:0] E_ESC_END    = 5'd10;
   localparam logic [4:0] E_BAD_ESC    = 5'd11;
   localparam logic [4:0] E_STR_UNTERM = 5'd12;
   localparam logic [4:0] E_HEX_TRUNC  = 5'd13;
   localparam logic [4:0] E_BAD_HEX    = 5'd14;
   localparam logic [4:0] E_LEAD_ZERO  = 5'd15;
   localparam logic [4:0] E_BAD_NUM    = 5'd16;
   localparam logic [4:0] E_BAD_FRAC   = 5'd17;
   localparam logic [4:0] E_BAD_EXP    = 5'd18;
   localparam logic [4:0] E_BAD_LIT    = 5'd19;
   localparam logic [4:0] E_TRAILING   = 5'd20;

   typedef struct packed {
      logic [3:0] event_res;
      logic       number_end;
      logic [7:0] data_first;
      logic [7:0] data_second;
      logic [7:0] data_third;
      logic [1:0] data_count;
      logic [5:0] nest_level;
      logic [4:0] error_code;
      logic       done_res;
   } result_type;

   function automatic logic [7:0] lit_char(input logic [3:0] pos);
      logic [7:0] c;
      begin
         case (pos)
            4'd0: c = 8'h74; 4'd1: c = 8'h72; 4'd2: c = 8'h75; 4'd3: c = 8'h65;
            4'd4: c = 8'h66; 4'd5: c = 8'h61; 4'd6: c = 8'h6C; 4'd7: c = 8'h73;
            4'd8: c = 8'h65; 4'd9: c = 8'h6E; 4'd10: c = 8'h75; 4'd11: c = 8'h6C;
            4'd12: c = 8'h6C;
            default: c = 8'h00;
         endcase
         return c;
      end
   endfunction

endpackage

>>> hw/rtl/jsv_core.sv
`timescale 1ns / 1ps
module jsv_core import jsv_pkg::*; #(
   parameter int MAX_NEST = 32,
   parameter int LW = 9
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       step,
   input  logic [7:0] text_byte,
   input  logic       finish,
   output result_type res
);

   localparam int KD = MAX_NEST + 1;
   localparam logic [LW-1:0] MAXN = LW'(MAX_NEST);

   phase_type     phase_ff, phase_in;
   logic [LW-1:0] level_ff, level_in;
   logic [15:0]   hex_ff, hex_in;
   logic [1:0]    hcnt_ff, hcnt_in;
   logic [3:0]    lpos_ff, lpos_in;
   logic          key_ff, key_in;
   logic [4:0]    err_ff, err_in;
   logic [KD-1:0] kinds_ff, kinds_in;
   logic          kw_en;
   logic          kw_val;
   logic          kpop_en;
   logic          top_kind;

   logic          is_ws, is_dig, expc, hex_ok;
   logic [3:0]    hex_d;
   logic [15:0]   cp;
   logic          nend;
   phase_type     p2, after_phase;

   assign is_ws  = text_byte == 8'h20 || text_byte == 8'h0A ||
                   text_byte == 8'h0D || text_byte == 8'h09;
   assign is_dig = text_byte >= 8'h30 && text_byte <= 8'h39;
   assign expc   = text_byte == 8'h65 || text_byte == 8'h45;
   assign top_kind = kinds_ff[0];

   always_comb begin
      hex_ok = 1'b1;
      hex_d  = 4'd0;
      if (is_dig) hex_d = text_byte[3:0];
      else if ((text_byte >= 8'h61 && text_byte <= 8'h66) ||
               (text_byte >= 8'h41 && text_byte <= 8'h46))
         hex_d = 4'(text_byte[2:0] + 3'd1) + 4'd8;
      else hex_ok = 1'b0;
   end
   assign cp = {hex_ff[11:0], hex_d};

   always_comb begin
      if (level_ff == '0) after_phase = P_AFTER_TOP;
      else if (level_ff <= MAXN + LW'(1) && top_kind == KIND_ARR) after_phase = P_ARR_AFTER;
      else after_phase = P_OBJ_AFTER;
   end

   always_comb begin
      logic [4:0] fcode;
      logic       open_c, close_c;
      logic       okind;
      phase_type  p;
      phase_type  next_num;
      logic       num_fail;
      logic [4:0] num_code;
      logic       num_ok;
      logic [3:0] lp1;
      fcode   = E_OK;
      open_c  = 1'b0;
      close_c = 1'b0;
      okind   = KIND_OBJ;
      next_num = P_FAILED;
      num_fail = 1'b0;
      num_code = E_OK;
      num_ok   = 1'b0;
      lp1      = lpos_ff + 4'd1;
      phase_in = phase_ff;
      level_in = level_ff;
      hex_in   = hex_ff;
      hcnt_in  = hcnt_ff;
      lpos_in  = lpos_ff;
      key_in   = key_ff;
      nend     = 1'b0;
      res      = '0;
      p        = phase_ff;
      p2       = phase_ff;

      if (finish) begin
         if (p == P_NUM_ZERO || p == P_NUM_INT || p == P_NUM_FRAC || p == P_NUM_EXP) begin
            nend = 1'b1;
            p = after_phase;
         end
         unique case (p)
            P_TOP, P_OBJ_VALUE:       fcode = E_END;
            P_ARR_FIRST, P_ARR_VALUE: fcode = E_ARR_UNTERM;
            P_ARR_AFTER:              fcode = E_ARR_COMMA;
            P_OBJ_FIRST, P_OBJ_KEY:   fcode = E_OBJ_UNTERM;
            P_OBJ_COLON:              fcode = E_COLON;
            P_OBJ_AFTER:              fcode = E_OBJ_COMMA;
            P_STR:                    fcode = E_STR_UNTERM;
            P_ESC:                    fcode = E_ESC_END;
            P_HEX:                    fcode = E_HEX_TRUNC;
            P_LIT:                    fcode = E_BAD_LIT;
            P_NUM_SIGN:               fcode = E_BAD_NUM;
            P_NUM_FRAC0:              fcode = E_BAD_FRAC;
            P_NUM_EXP0, P_NUM_EXPSIGN: fcode = E_BAD_EXP;
            default:                  fcode = E_OK;
         endcase
         res.done_res = 1'b1;
      end else begin
         if (p >= P_NUM_SIGN && p <= P_NUM_EXP) begin
            unique case (p)
               P_NUM_SIGN: begin
                  if (text_byte == 8'h30) next_num = P_NUM_ZERO;
                  else if (is_dig) next_num = P_NUM_INT;
                  else begin num_fail = 1'b1; num_code = E_BAD_NUM; end
               end
               P_NUM_ZERO, P_NUM_INT: begin
                  if (is_dig && p == P_NUM_ZERO) begin
                     num_fail = 1'b1; num_code = E_LEAD_ZERO;
                  end else if (is_dig) next_num = P_NUM_INT;
                  else if (text_byte == 8'h2E) next_num = P_NUM_FRAC0;
                  else if (expc) next_num = P_NUM_EXP0;
               end
               P_NUM_FRAC0: begin
                  if (is_dig) next_num = P_NUM_FRAC;
                  else begin num_fail = 1'b1; num_code = E_BAD_FRAC; end
               end
               P_NUM_FRAC: begin
                  if (is_dig) next_num = P_NUM_FRAC;
                  else if (expc) next_num = P_NUM_EXP0;
               end
               P_NUM_EXP0: begin
                  if (text_byte == 8'h2B || text_byte == 8'h2D) next_num = P_NUM_EXPSIGN;
                  else if (is_dig) next_num = P_NUM_EXP;
                  else begin num_fail = 1'b1; num_code = E_BAD_EXP; end
               end
               P_NUM_EXPSIGN: begin
                  if (is_dig) next_num = P_NUM_EXP;
                  else begin num_fail = 1'b1; num_code = E_BAD_EXP; end
               end
               default: begin
                  if (is_dig) next_num = P_NUM_EXP;
               end
            endcase
            if (num_fail) fcode = num_code;
            else if (next_num == P_FAILED) begin
               nend = 1'b1;
               p2 = after_phase;
               phase_in = after_phase;
            end else begin
               num_ok = 1'b1;
               res.event_res = EV_NUM;
               phase_in = next_num;
            end
         end
         if (!num_ok && fcode == E_OK) begin
            unique case (p2)
               P_TOP, P_OBJ_VALUE, P_ARR_FIRST, P_ARR_VALUE: begin
                  if (!is_ws) begin
                     if (p2 == P_ARR_FIRST && text_byte == 8'h5D) close_c = 1'b1;
                     else if ((p2 == P_ARR_FIRST || p2 == P_ARR_VALUE) && level_ff > MAXN)
                        fcode = E_DEPTH;
                     else if (text_byte == 8'h7B) begin
                        open_c = 1'b1; okind = KIND_OBJ;
                        res.event_res = EV_OBJ_OPEN; phase_in = P_OBJ_FIRST;
                     end else if (text_byte == 8'h5B) begin
                        open_c = 1'b1; okind = KIND_ARR;
                        res.event_res = EV_ARR_OPEN; phase_in = P_ARR_FIRST;
                     end else if (text_byte == 8'h22) begin
                        key_in = 1'b0; phase_in = P_STR;
                     end else if (text_byte == 8'h74) begin
                        lpos_in = 4'd0; phase_in = P_LIT;
                     end else if (text_byte == 8'h66) begin
                        lpos_in = 4'd4; phase_in = P_LIT;
                     end else if (text_byte == 8'h6E) begin
                        lpos_in = 4'd9; phase_in = P_LIT;
                     end else if (text_byte == 8'h2D) begin
                        res.event_res = EV_NUM; phase_in = P_NUM_SIGN;
                     end else if (text_byte == 8'h30) begin
                        res.event_res = EV_NUM; phase_in = P_NUM_ZERO;
                     end else if (is_dig) begin
                        res.event_res = EV_NUM; phase_in = P_NUM_INT;
                     end else fcode = E_BAD_NUM;
                     if (close_c) res.event_res = EV_ARR_CLOSE;
                  end
               end
               P_AFTER_TOP: if (!is_ws) fcode = E_TRAILING;
               P_ARR_AFTER: begin
                  if (!is_ws) begin
                     if (text_byte == 8'h5D) begin
                        close_c = 1'b1; res.event_res = EV_ARR_CLOSE;
                     end else if (text_byte == 8'h2C) phase_in = P_ARR_VALUE;
                     else fcode = E_ARR_COMMA;
                  end
               end
               P_OBJ_FIRST, P_OBJ_KEY: begin
                  if (!is_ws) begin
                     if (p2 == P_OBJ_FIRST && text_byte == 8'h7D) begin
                        close_c = 1'b1; res.event_res = EV_OBJ_CLOSE;
                     end else if (text_byte == 8'h22) begin
                        key_in = 1'b1; phase_in = P_STR;
                     end else fcode = E_EXP_STR;
                  end
               end
               P_OBJ_COLON: begin
                  if (!is_ws) begin
                     if (text_byte != 8'h3A) fcode = E_COLON;
                     else if (level_ff > MAXN) fcode = E_DEPTH;
                     else phase_in = P_OBJ_VALUE;
                  end
               end
               P_OBJ_AFTER: begin
                  if (!is_ws) begin
                     if (text_byte == 8'h7D) begin
                        close_c = 1'b1; res.event_res = EV_OBJ_CLOSE;
                     end else if (text_byte == 8'h2C) phase_in = P_OBJ_KEY;
                     else fcode = E_OBJ_COMMA;
                  end
               end
               P_STR: begin
                  if (text_byte == 8'h22) begin
                     res.event_res = key_ff ? EV_KEY_END : EV_STR_END;
                     if (key_ff) begin
                        key_in = 1'b0; phase_in = P_OBJ_COLON;
                     end else phase_in = after_phase;
                  end else if (text_byte < 8'h20) fcode = E_CTRL;
                  else if (text_byte == 8'h5C) phase_in = P_ESC;
                  else begin
                     res.event_res = key_ff ? EV_KEY_DATA : EV_STR_DATA;
                     res.data_first = text_byte; res.data_count = 2'd1;
                  end
               end
               P_ESC: begin
                  res.data_count = 2'd1;
                  res.event_res = key_ff ? EV_KEY_DATA : EV_STR_DATA;
                  phase_in = P_STR;
                  case (text_byte)
                     8'h22, 8'h5C, 8'h2F: res.data_first = text_byte;
                     8'h62: res.data_first = 8'h08;
                     8'h66: res.data_first = 8'h0C;
                     8'h6E: res.data_first = 8'h0A;
                     8'h72: res.data_first = 8'h0D;
                     8'h74: res.data_first = 8'h09;
                     8'h75: begin
                        res.data_count = 2'd0; res.event_res = EV_NONE;
                        hex_in = '0; hcnt_in = '0; phase_in = P_HEX;
                     end
                     default: begin
                        res.data_count = 2'd0; res.event_res = EV_NONE;
                        fcode = E_BAD_ESC;
                     end
                  endcase
               end
               P_HEX: begin
                  if (!hex_ok) fcode = E_BAD_HEX;
                  else if (hcnt_ff != 2'd3) begin
                     hex_in = cp; hcnt_in = hcnt_ff + 2'd1;
                  end else begin
                     hex_in = '0; hcnt_in = '0; phase_in = P_STR;
                     res.event_res = key_ff ? EV_KEY_DATA : EV_STR_DATA;
                     if (cp <= 16'h7F) begin
                        res.data_first = cp[7:0]; res.data_count = 2'd1;
                     end else if (cp <= 16'h7FF) begin
                        res.data_first  = 8'hC0 | {3'b0, cp[10:6]};
                        res.data_second = 8'h80 | {2'b0, cp[5:0]};
                        res.data_count  = 2'd2;
                     end else begin
                        res.data_first  = 8'hE0 | {4'b0, cp[15:12]};
                        res.data_second = 8'h80 | {2'b0, cp[11:6]};
                        res.data_third  = 8'h80 | {2'b0, cp[5:0]};
                        res.data_count  = 2'd3;
                     end
                  end
               end
               P_LIT: begin
                  if (lpos_ff >= 4'd12 || text_byte != lit_char(lp1)) fcode = E_BAD_LIT;
                  else if (lp1 == 4'd3 || lp1 == 4'd8 || lp1 == 4'd12) begin
                     res.event_res = (lp1 == 4'd3) ? EV_TRUE :
                                     (lp1 == 4'd8) ? EV_FALSE : EV_NULL;
                     lpos_in = 4'd0; phase_in = after_phase;
                  end else lpos_in = lp1;
               end
               default: ;
            endcase
         end
      end

      if (open_c && level_ff <= MAXN) level_in = level_ff + LW'(1);
      if (close_c) begin
         if (level_ff != '0) level_in = level_ff - LW'(1);
      end
      kw_en   = open_c && level_ff <= MAXN;
      kw_val  = okind;
      kpop_en = close_c && level_ff != '0;

      err_in = err_ff;
      if (fcode != E_OK) begin
         phase_in = P_FAILED;
         if (err_ff == E_OK) err_in = fcode;
      end
      res.number_end = nend;
      res.nest_level = 6'(level_in);
      res.error_code = err_in;
   end

   // take the phase after a close from the kind below the top
   phase_type close_after;
   always_comb begin
      if (level_ff <= LW'(1)) close_after = P_AFTER_TOP;
      else if (level_ff <= MAXN + LW'(2) && kinds_ff[1] == KIND_ARR)
         close_after = P_ARR_AFTER;
      else close_after = P_OBJ_AFTER;
   end

   logic is_close;
   assign is_close = res.event_res == EV_OBJ_CLOSE || res.event_res == EV_ARR_CLOSE;

   always_comb begin
      kinds_in = kinds_ff;
      if (kw_en) kinds_in = {kinds_ff[KD-2:0], kw_val};
      else if (kpop_en) kinds_in = {1'b0, kinds_ff[KD-1:1]};
   end

   always_ff @(posedge clock) begin
      if (step && !finish) kinds_ff <= kinds_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= P_TOP;
         level_ff <= '0;
         hex_ff   <= '0;
         hcnt_ff  <= '0;
         lpos_ff  <= '0;
         key_ff   <= 1'b0;
         err_ff   <= E_OK;
      end else if (step) begin
         if (finish) begin
            phase_ff <= P_TOP;
            level_ff <= '0;
            hex_ff   <= '0;
            hcnt_ff  <= '0;
            lpos_ff  <= '0;
            key_ff   <= 1'b0;
            err_ff   <= E_OK;
         end else begin
            phase_ff <= (is_close && phase_in != P_FAILED) ? close_after : phase_in;
            level_ff <= level_in;
            hex_ff   <= hex_in;
            hcnt_ff  <= hcnt_in;
            lpos_ff  <= lpos_in;
            key_ff   <= key_in;
            err_ff   <= err_in;
         end
      end
   end

endmodule

>>> hw/rtl/jsv_out_reg.sv
`timescale 1ns / 1ps
module jsv_out_reg import jsv_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       load,
   input  result_type load_data,
   input  logic       take,
   output logic       full,
   output result_type data
);

   logic       full_ff, full_in;
   result_type data_ff;

   assign full_in = load | (full_ff & ~take);

   always_ff @(posedge clock) begin
      if (reset) full_ff <= 1'b0;
      else full_ff <= full_in;
   end

   always_ff @(posedge clock) begin
      if (load) data_ff <= load_data;
   end

   assign full = full_ff;
   assign data = data_ff;

endmodule

>>> hw/rtl/json_stream_validator_top.sv
`timescale 1ns / 1ps
// The result of an input transaction is registered in the output register and is on the rsp_ ports in the next cycle.
// One byte per cycle while the output register is empty or rsp_ready is high; the phase update is combinational.
// A new byte is taken while a result is held, provided the output register drains.
// Reset (synchronous, active high) returns the parser to the top-level phase
// and empties the output register.
module json_stream_validator_top import jsv_pkg::*; #(
   parameter int MAX_NEST = 32
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_text_byte,
   input  logic       req_finish,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [3:0] rsp_event_res,
   output logic       rsp_number_end,
   output logic [7:0] rsp_data_first,
   output logic [7:0] rsp_data_second,
   output logic [7:0] rsp_data_third,
   output logic [1:0] rsp_data_count,
   output logic [5:0] rsp_nest_level,
   output logic [4:0] rsp_error_code,
   output logic       rsp_done_res
);

   localparam int LW = $clog2(MAX_NEST + 3);

   result_type res, held;
   logic       full, step;

   assign req_ready = ~full | rsp_ready;
   assign step      = req_valid & req_ready;

   jsv_core #(.MAX_NEST(MAX_NEST), .LW(LW)) u_core (
      .clock(clock), .reset(reset), .step(step),
      .text_byte(req_text_byte), .finish(req_finish), .res(res)
   );

   jsv_out_reg u_out (
      .clock(clock), .reset(reset), .load(step), .load_data(res),
      .take(rsp_ready), .full(full), .data(held)
   );

   assign rsp_valid       = full;
   assign rsp_event_res   = held.event_res;
   assign rsp_number_end  = held.number_end;
   assign rsp_data_first  = held.data_first;
   assign rsp_data_second = held.data_second;
   assign rsp_data_third  = held.data_third;
   assign rsp_data_count  = held.data_count;
   assign rsp_nest_level  = held.nest_level;
   assign rsp_error_code  = held.error_code;
   assign rsp_done_res    = held.done_res;

endmodule

>>> hw/rtl/jsv_checker.sv
`timescale 1ns / 1ps
module jsv_checker import jsv_pkg::*; (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [3:0] rsp_event_res,
   input logic [1:0] rsp_data_count,
   input logic [4:0] rsp_error_code,
   input logic       rsp_done_res
);

   a_one_latency: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> rsp_valid) else $error("result missing");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_event_res)))
      else $error("stalled result changed");

   a_data_event: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data_count != 2'd0) |->
      (rsp_event_res == EV_KEY_DATA || rsp_event_res == EV_STR_DATA))
      else $error("data without data event");

   a_done_quiet: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_done_res) |-> (rsp_data_count == 2'd0))
      else $error("data on finish result");

   a_err_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_error_code <= E_TRAILING))
      else $error("error code out of range");

endmodule

bind json_stream_validator_top jsv_checker u_chk (
   .clock(clock), .reset(reset), .req_valid(req_valid), .req_ready(req_ready),
   .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_event_res(rsp_event_res),
   .rsp_data_count(rsp_data_count), .rsp_error_code(rsp_error_code),
   .rsp_done_res(rsp_done_res)
);

>>> sim/tb_json_stream_validator_top.sv
`timescale 1ns / 1ps
module tb_json_stream_validator_top;
   import jsv_pkg::*;

   localparam int MAX_NEST  = 32;
   localparam int CYCLE_CAP = 400000;

   class json_token_scoreboard;
      phase_type   phase;
      logic        kinds [0:MAX_NEST];
      int unsigned depth;
      logic [15:0] hex_acc;
      int unsigned hex_cnt;
      int unsigned lit_pos;
      bit          key_mode;
      logic [4:0]  first_err;
      result_type  pending [$];
      result_type  cur;
      int          mismatches;

      function void clear_doc();
         phase = P_TOP;
         foreach (kinds[i]) kinds[i] = KIND_OBJ;
         depth = 0; hex_acc = '0; hex_cnt = 0; lit_pos = 0;
         key_mode = 0; first_err = E_OK;
      endfunction

      function void raise(logic [4:0] code);
         if (first_err == E_OK) first_err = code;
         phase = P_FAILED;
      endfunction

      function bit is_space(logic [7:0] c);
         return c == 8'h20 || c == 8'h0A || c == 8'h0D || c == 8'h09;
      endfunction

      function bit is_dig(logic [7:0] c);
         return c >= 8'h30 && c <= 8'h39;
      endfunction

      function void after_value();
         if (depth == 0) phase = P_AFTER_TOP;
         else if (kinds[depth - 1] == KIND_ARR) phase = P_ARR_AFTER;
         else phase = P_OBJ_AFTER;
      endfunction

      function void open_nest(logic kind, logic [3:0] ev, phase_type nxt);
         if (depth <= MAX_NEST) begin
            kinds[depth] = kind;
            depth++;
         end
         cur.event_res = ev;
         phase = nxt;
      endfunction

      function void close_nest(logic [3:0] ev);
         if (depth > 0) depth--;
         cur.event_res = ev;
         after_value();
      endfunction

      function void put_data(logic [7:0] b);
         cur.event_res = key_mode ? EV_KEY_DATA : EV_STR_DATA;
         cur.data_first = b;
         cur.data_count = 1;
      endfunction

      function void begin_value(logic [7:0] c);
         if (c == 8'h7B) open_nest(KIND_OBJ, EV_OBJ_OPEN, P_OBJ_FIRST);
         else if (c == 8'h5B) open_nest(KIND_ARR, EV_ARR_OPEN, P_ARR_FIRST);
         else if (c == 8'h22) begin
            key_mode = 0;
            phase = P_STR;
         end else if (c == 8'h74 || c == 8'h66 || c == 8'h6E) begin
            lit_pos = (c == 8'h74) ? 0 : (c == 8'h66) ? 4 : 9;
            phase = P_LIT;
         end else if (c == 8'h2D) begin
            cur.event_res = EV_NUM;
            phase = P_NUM_SIGN;
         end else if (c == 8'h30) begin
            cur.event_res = EV_NUM;
            phase = P_NUM_ZERO;
         end else if (is_dig(c)) begin
            cur.event_res = EV_NUM;
            phase = P_NUM_INT;
         end else raise(E_BAD_NUM);
      endfunction

      function int hex_of(logic [7:0] c);
         if (is_dig(c)) return c - 8'h30;
         if (c >= 8'h61 && c <= 8'h66) return c - 8'h61 + 10;
         if (c >= 8'h41 && c <= 8'h46) return c - 8'h41 + 10;
         return -1;
      endfunction

      function void escape_char(logic [7:0] c);
         logic [7:0] b;
         case (c)
            8'h22, 8'h5C, 8'h2F: b = c;
            8'h62: b = 8'h08;
            8'h66: b = 8'h0C;
            8'h6E: b = 8'h0A;
            8'h72: b = 8'h0D;
            8'h74: b = 8'h09;
            8'h75: begin
               hex_acc = '0; hex_cnt = 0; phase = P_HEX;
               return;
            end
            default: begin
               raise(E_BAD_ESC);
               return;
            end
         endcase
         put_data(b);
         phase = P_STR;
      endfunction

      function void hex_char(logic [7:0] c);
         int d;
         logic [15:0] cp;
         d = hex_of(c);
         if (d < 0) begin
            raise(E_BAD_HEX);
            return;
         end
         cp = {hex_acc[11:0], 4'(d)};
         if (hex_cnt < 3) begin
            hex_acc = cp; hex_cnt++;
            return;
         end
         hex_acc = '0; hex_cnt = 0; phase = P_STR;
         cur.event_res = key_mode ? EV_KEY_DATA : EV_STR_DATA;
         if (cp <= 16'h7F) begin
            cur.data_first = cp[7:0]; cur.data_count = 1;
         end else if (cp <= 16'h7FF) begin
            cur.data_first = 8'hC0 | {3'b0, cp[10:6]};
            cur.data_second = 8'h80 | {2'b0, cp[5:0]};
            cur.data_count = 2;
         end else begin
            cur.data_first = 8'hE0 | {4'b0, cp[15:12]};
            cur.data_second = 8'h80 | {2'b0, cp[11:6]};
            cur.data_third = 8'h80 | {2'b0, cp[5:0]};
            cur.data_count = 3;
         end
      endfunction

      function void literal_char(logic [7:0] c);
         if (lit_pos >= 12 || c != lit_char(4'(lit_pos + 1))) begin
            raise(E_BAD_LIT);
            return;
         end
         lit_pos++;
         if (lit_pos == 3 || lit_pos == 8 || lit_pos == 12) begin
            cur.event_res = (lit_pos == 3) ? EV_TRUE : (lit_pos == 8) ? EV_FALSE : EV_NULL;
            lit_pos = 0;
            after_value();
         end
      endfunction

      function bit number_char(logic [7:0] c);
         bit dig, expc, ended;
         phase_type nxt;
         dig = is_dig(c);
         expc = c == 8'h65 || c == 8'h45;
         ended = 1;
         nxt = P_FAILED;
         case (phase)
            P_NUM_SIGN: begin
               if (c == 8'h30) nxt = P_NUM_ZERO;
               else if (dig) nxt = P_NUM_INT;
               else begin raise(E_BAD_NUM); return 0; end
            end
            P_NUM_ZERO, P_NUM_INT: begin
               if (dig && phase == P_NUM_ZERO) begin raise(E_LEAD_ZERO); return 0; end
               if (dig) nxt = P_NUM_INT;
               else if (c == 8'h2E) nxt = P_NUM_FRAC0;
               else if (expc) nxt = P_NUM_EXP0;
            end
            P_NUM_FRAC0: begin
               if (dig) nxt = P_NUM_FRAC;
               else begin raise(E_BAD_FRAC); return 0; end
            end
            P_NUM_FRAC: begin
               if (dig) nxt = P_NUM_FRAC;
               else if (expc) nxt = P_NUM_EXP0;
            end
            P_NUM_EXP0: begin
               if (c == 8'h2B || c == 8'h2D) nxt = P_NUM_EXPSIGN;
               else if (dig) nxt = P_NUM_EXP;
               else begin raise(E_BAD_EXP); return 0; end
            end
            P_NUM_EXPSIGN: begin
               if (dig) nxt = P_NUM_EXP;
               else begin raise(E_BAD_EXP); return 0; end
            end
            default: if (dig) nxt = P_NUM_EXP;
         endcase
         if (nxt == P_FAILED) begin
            cur.number_end = ended;
            after_value();
            return 1;
         end
         cur.event_res = EV_NUM;
         phase = nxt;
         return 0;
      endfunction

      function bit byte_step(logic [7:0] c);
         if (phase >= P_NUM_SIGN && phase <= P_NUM_EXP) return number_char(c);
         case (phase)
            P_TOP, P_OBJ_VALUE: if (!is_space(c)) begin_value(c);
            P_AFTER_TOP: if (!is_space(c)) raise(E_TRAILING);
            P_ARR_FIRST, P_ARR_VALUE: if (!is_space(c)) begin
               if (phase == P_ARR_FIRST && c == 8'h5D) close_nest(EV_ARR_CLOSE);
               else if (depth > MAX_NEST) raise(E_DEPTH);
               else begin_value(c);
            end
            P_ARR_AFTER: if (!is_space(c)) begin
               if (c == 8'h5D) close_nest(EV_ARR_CLOSE);
               else if (c == 8'h2C) phase = P_ARR_VALUE;
               else raise(E_ARR_COMMA);
            end
            P_OBJ_FIRST, P_OBJ_KEY: if (!is_space(c)) begin
               if (phase == P_OBJ_FIRST && c == 8'h7D) close_nest(EV_OBJ_CLOSE);
               else if (c == 8'h22) begin
                  key_mode = 1; phase = P_STR;
               end else raise(E_EXP_STR);
            end
            P_OBJ_COLON: if (!is_space(c)) begin
               if (c != 8'h3A) raise(E_COLON);
               else if (depth > MAX_NEST) raise(E_DEPTH);
               else phase = P_OBJ_VALUE;
            end
            P_OBJ_AFTER: if (!is_space(c)) begin
               if (c == 8'h7D) close_nest(EV_OBJ_CLOSE);
               else if (c == 8'h2C) phase = P_OBJ_KEY;
               else raise(E_OBJ_COMMA);
            end
            P_STR: begin
               if (c == 8'h22) begin
                  cur.event_res = key_mode ? EV_KEY_END : EV_STR_END;
                  if (key_mode) begin
                     key_mode = 0; phase = P_OBJ_COLON;
                  end else after_value();
               end else if (c < 8'h20) raise(E_CTRL);
               else if (c == 8'h5C) phase = P_ESC;
               else put_data(c);
            end
            P_ESC: escape_char(c);
            P_HEX: hex_char(c);
            P_LIT: literal_char(c);
            default: ;
         endcase
         return 0;
      endfunction

      function void end_doc();
         if (phase inside {P_NUM_ZERO, P_NUM_INT, P_NUM_FRAC, P_NUM_EXP}) begin
            cur.number_end = 1;
            after_value();
         end
         case (phase)
            P_TOP, P_OBJ_VALUE: raise(E_END);
            P_ARR_FIRST, P_ARR_VALUE: raise(E_ARR_UNTERM);
            P_ARR_AFTER: raise(E_ARR_COMMA);
            P_OBJ_FIRST, P_OBJ_KEY: raise(E_OBJ_UNTERM);
            P_OBJ_COLON: raise(E_COLON);
            P_OBJ_AFTER: raise(E_OBJ_COMMA);
            P_STR: raise(E_STR_UNTERM);
            P_ESC: raise(E_ESC_END);
            P_HEX: raise(E_HEX_TRUNC);
            P_LIT: raise(E_BAD_LIT);
            P_NUM_SIGN: raise(E_BAD_NUM);
            P_NUM_FRAC0: raise(E_BAD_FRAC);
            P_NUM_EXP0, P_NUM_EXPSIGN: raise(E_BAD_EXP);
            default: ;
         endcase
      endfunction

      function void note_request(logic [7:0] c, logic fin);
         cur = '0;
         if (fin) begin
            end_doc();
            cur.done_res = 1;
         end else if (byte_step(c)) void'(byte_step(c));
         cur.nest_level = 6'(depth);
         cur.error_code = first_err;
         if (fin) clear_doc();
         pending = {pending, cur};
      endfunction

      function void check_result(result_type got);
         result_type exp;
         if (pending.size() == 0) begin
            $error("unexpected result transaction");
            mismatches++;
            return;
         end
         exp = pending.pop_front();
         if (got.event_res != exp.event_res) begin
            $error("event_res exp %0d got %0d", exp.event_res, got.event_res); mismatches++;
         end
         if (got.number_end != exp.number_end) begin
            $error("number_end exp %0d got %0d", exp.number_end, got.number_end); mismatches++;
         end
         if (got.data_first != exp.data_first) begin
            $error("data_first exp %0h got %0h", exp.data_first, got.data_first); mismatches++;
         end
         if (got.data_second != exp.data_second) begin
            $error("data_second exp %0h got %0h", exp.data_second, got.data_second);
            mismatches++;
         end
         if (got.data_third != exp.data_third) begin
            $error("data_third exp %0h got %0h", exp.data_third, got.data_third); mismatches++;
         end
         if (got.data_count != exp.data_count) begin
            $error("data_count exp %0d got %0d", exp.data_count, got.data_count); mismatches++;
         end
         if (got.nest_level != exp.nest_level) begin
            $error("nest_level exp %0d got %0d", exp.nest_level, got.nest_level); mismatches++;
         end
         if (got.error_code != exp.error_code) begin
            $error("error_code exp %0d got %0d", exp.error_code, got.error_code); mismatches++;
         end
         if (got.done_res != exp.done_res) begin
            $error("done_res exp %0d got %0d", exp.done_res, got.done_res); mismatches++;
         end
      endfunction
   endclass

   logic       clock = 0;
   logic       reset = 1;
   logic       req_valid = 0;
   logic       req_ready;
   logic [7:0] req_text_byte = '0;
   logic       req_finish = 0;
   logic       rsp_valid;
   logic       rsp_ready = 0;
   result_type rsp_bus;

   json_token_scoreboard board;
   int   cycles = 0;
   int   send_idle_pct = 6;
   int   recv_idle_pct = 45;
   int   items_sent = 0;
   byte  doc_buf [$];

   json_stream_validator_top #(.MAX_NEST(MAX_NEST)) u_top (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_text_byte(req_text_byte), .req_finish(req_finish),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_event_res(rsp_bus.event_res), .rsp_number_end(rsp_bus.number_end),
      .rsp_data_first(rsp_bus.data_first), .rsp_data_second(rsp_bus.data_second),
      .rsp_data_third(rsp_bus.data_third), .rsp_data_count(rsp_bus.data_count),
      .rsp_nest_level(rsp_bus.nest_level), .rsp_error_code(rsp_bus.error_code),
      .rsp_done_res(rsp_bus.done_res)
   );

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_CAP) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready) board.check_result(rsp_bus);
         rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   task automatic send_item(logic [7:0] c, logic fin);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 0;
         @(posedge clock);
      end
      req_valid <= 1;
      req_text_byte <= c;
      req_finish <= fin;
      do @(posedge clock); while (!req_ready);
      board.note_request(c, fin);
      items_sent++;
   endtask

   task automatic send_text(string s, bit fin);
      foreach (s[i]) send_item(s[i], 0);
      if (fin) send_item(8'h00, 1);
   endtask

   task automatic send_buf();
      foreach (doc_buf[i]) send_item(doc_buf[i], 0);
      send_item(8'($urandom), 1);
      doc_buf.delete();
   endtask

   task automatic push_s(string s);
      foreach (s[i]) doc_buf = {doc_buf, s[i]};
   endtask

   function automatic string rand_number();
      string s;
      s = "";
      if ($urandom_range(3) == 0) s = "-";
      if ($urandom_range(3) == 0) s = {s, "0"};
      else begin
         s = {s, string'(byte'(8'h31 + $urandom_range(8)))};
         repeat ($urandom_range(3)) s = {s, string'(byte'(8'h30 + $urandom_range(9)))};
      end
      if ($urandom_range(2) == 0) begin
         s = {s, "."};
         repeat ($urandom_range(1, 3)) s = {s, string'(byte'(8'h30 + $urandom_range(9)))};
      end
      if ($urandom_range(3) == 0) begin
         if ($urandom_range(1)) s = {s, "e"};
         else s = {s, "E"};
         case ($urandom_range(2))
            0: s = {s, "+"};
            1: s = {s, "-"};
            default: ;
         endcase
         repeat ($urandom_range(1, 2)) s = {s, string'(byte'(8'h30 + $urandom_range(9)))};
      end
      return s;
   endfunction

   function automatic string rand_string();
      string s;
      string esc_set;
      logic [15:0] cp;
      esc_set = "\"\\/bfnrt";
      s = "\"";
      repeat ($urandom_range(4)) begin
         case ($urandom_range(5))
            0: s = {s, "\\", string'(esc_set[$urandom_range(7)])};
            1: begin
               cp = 16'($urandom);
               if ($urandom_range(1)) cp = cp & 16'h07FF;
               s = {s, $sformatf("\\u%04h", cp)};
            end
            2: s = {s, string'(byte'($urandom_range(8'h80, 8'hFF)))};
            default: s = {s, string'(byte'($urandom_range(8'h20, 8'h7E) == 8'h22 ? 8'h41
                                                     : $urandom_range(8'h23, 8'h5B)))};
         endcase
      end
      return {s, "\""};
   endfunction

   function automatic string rand_value(int lvl);
      string s;
      int n;
      case (lvl > 3 ? $urandom_range(4) : $urandom_range(6))
         0: return rand_number();
         1: return rand_string();
         2: return "true";
         3: begin
            if ($urandom_range(1)) return "false";
            return "null";
         end
         4: return rand_number();
         5: begin
            s = "[";
            n = $urandom_range(3);
            for (int i = 0; i < n; i++) begin
               if (i != 0) s = {s, ", "};
               s = {s, rand_value(lvl + 1)};
            end
            return {s, "]"};
         end
         default: begin
            s = "{";
            n = $urandom_range(3);
            for (int i = 0; i < n; i++) begin
               if (i != 0) s = {s, ","};
               s = {s, rand_string(), " : ", rand_value(lvl + 1)};
            end
            return {s, "}"};
         end
      endcase
   endfunction

   task automatic random_doc();
      string s;
      int cut;
      s = "";
      if ($urandom_range(1)) s = " ";
      s = {s, rand_value(0)};
      if ($urandom_range(3) == 0) s = {s, "\n"};
      push_s(s);
      case ($urandom_range(9))
         0: doc_buf[$urandom_range(doc_buf.size() - 1)] = byte'($urandom);
         1: begin
            cut = $urandom_range(doc_buf.size() - 1);
            while (doc_buf.size() > cut) void'(doc_buf.pop_back());
         end
         2: repeat ($urandom_range(1, 4)) doc_buf = {doc_buf, byte'($urandom)};
         default: ;
      endcase
      send_buf();
   endtask

   task automatic drain();
      req_valid <= 0;
      while (board.pending.size() != 0) @(posedge clock);
   endtask

   initial begin
      board = new();
      board.clear_doc();
      repeat (5) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      send_text("{\"k\":[0,-1.5e+3,12E2,true,false,null,\"a\\n\\u00e9\\u20AC\\u0041\"]}", 1);
      send_text("[]", 1);
      send_text("01", 1);
      send_text("\"\\x\"", 1);
      send_text("\"\\u12G4\"", 1);
      send_text("\"\\u12", 1);
      send_text("{\"a\" 1}", 1);
      send_text("1.e5", 1);
      send_text("tru", 1);
      send_text("1 2", 1);
      send_text("\"\t\"", 1);
      send_text("\xff\x00", 1);
      drain();

      for (int i = 0; i < 34; i++) push_s("[");
      send_buf();
      for (int i = 0; i < 33; i++) push_s("{\"a\":");
      push_s("1");
      send_buf();
      drain();

      for (int ph = 0; ph < 3; ph++) begin
         send_idle_pct = (ph == 0) ? 6 : (ph == 1) ? 45 : 0;
         recv_idle_pct = (ph == 0) ? 45 : (ph == 1) ? 6 : 0;
         while (items_sent < 550 * (ph + 1)) begin
            if ($urandom_range(7) == 0) begin
               repeat ($urandom_range(1, 6)) doc_buf = {doc_buf, byte'($urandom)};
               send_buf();
            end else random_doc();
         end
      end

      drain();
      repeat (20) @(posedge clock);
      if (board.mismatches == 0 && board.pending.size() == 0) $display("RESULT: OK");
      else $display("RESULT: ERROR");
      $finish;
   end
endmodule
